/* design/atcw_pkg.sv */
// Shared types, byte codes and helper functions for the ANSI text console writer.
// No dependencies; atcw_store, atcw_seq and the top level refer to this package by scoped names.
package atcw_pkg;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_THREE   = 8'h33;
   localparam logic [7:0] CH_M       = 8'h6D;
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_FIRST   = 8'h20;
   localparam logic [7:0] CH_LAST    = 8'h7E;

   localparam logic [3:0] COLOUR_DEFAULT = 4'd7;
   localparam logic [7:0] COLOUR_BASE    = 8'd8;

   // escape parser stages
   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_ESC     = 3'd1;
   localparam logic [2:0] E_BRACKET = 3'd2;
   localparam logic [2:0] E_ZERO    = 3'd3;
   localparam logic [2:0] E_ONE     = 3'd4;
   localparam logic [2:0] E_SEMI    = 3'd5;
   localparam logic [2:0] E_THREE   = 3'd6;
   localparam logic [2:0] E_DIGIT   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_LIT,
      ST_RD,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic cell_we;
      logic fill_we;
      logic row_inv;
      logic clr_all;
      logic rd;
   } store_ctl_type;

   typedef struct packed {
      logic [6:0] cell_char;
      logic [3:0] cell_colour;
      logic [6:0] cursor_column;
      logic [3:0] colour_now;
   } result_type;

   // number of literal bytes replayed when an escape breaks at a stage
   function automatic logic [2:0] lit_len(input logic [2:0] st);
      logic [2:0] n;
      case (st)
         E_BRACKET: n = 3'd1;
         E_ZERO:    n = 3'd2;
         E_ONE:     n = 3'd2;
         E_SEMI:    n = 3'd3;
         E_THREE:   n = 3'd4;
         E_DIGIT:   n = 3'd4;
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] lit_byte(input logic [2:0] st, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = CH_BRACKET;
         2'd1:    b = (st == E_ZERO) ? CH_ZERO : CH_ONE;
         2'd2:    b = CH_SEMI;
         default: b = CH_THREE;
      endcase
      return b;
   endfunction

endpackage

/* design/atcw_if.sv */
// Request and response channel interfaces of the ANSI text console writer.
// Depends on nothing; payload fields follow the request and result items.
interface atcw_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [5:0] row;
   logic [6:0] column;

   modport source(output valid, kind, data_byte, row, column, input ready);
   modport sink(input valid, kind, data_byte, row, column, output ready);
endinterface

interface atcw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] cell_char;
   logic [3:0] cell_colour;
   logic [6:0] cursor_column;
   logic [3:0] colour_now;

   modport source(output valid, cell_char, cell_colour, cursor_column, colour_now,
                  input ready);
   modport sink(input valid, cell_char, cell_colour, cursor_column, colour_now,
                output ready);
endinterface

/* design/atcw_store.sv */
// Character grid memory and per-row fill memory with row valid bits.
// Depends on atcw_pkg (store_ctl_type).
module atcw_store #(
   parameter int COLUMNS = 120,
   parameter int ROWS = 35,
   localparam int RW = $clog2(ROWS),
   localparam int CW = $clog2(COLUMNS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  atcw_pkg::store_ctl_type ctl,
   input  logic [RW-1:0]           wr_row,
   input  logic [CW-1:0]           wr_col,
   input  logic [10:0]             wr_cell,
   input  logic [CW-1:0]           fill_value,
   input  logic [RW-1:0]           rd_row,
   input  logic [CW-1:0]           rd_col,
   output logic [10:0]             rd_cell,
   output logic [CW-1:0]           rd_fill
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW = $clog2(DEPTH);

   logic [10:0]   cells_ff [DEPTH];
   logic [CW-1:0] fills_ff [ROWS];
   logic [ROWS-1:0] row_vld_ff, row_vld_in;
   logic [10:0]   cell_rd_ff;
   logic [CW-1:0] fill_rd_ff;
   logic          vld_rd_ff;
   logic [AW-1:0] waddr, raddr;

   assign waddr = AW'(AW'(wr_row) * AW'(COLUMNS) + AW'(wr_col));
   assign raddr = AW'(AW'(rd_row) * AW'(COLUMNS) + AW'(rd_col));

   always_ff @(posedge clock) begin
      if (ctl.cell_we) begin
         cells_ff[waddr] <= wr_cell;
      end
      if (ctl.fill_we) begin
         fills_ff[wr_row] <= fill_value;
      end
      if (ctl.rd) begin
         cell_rd_ff <= cells_ff[raddr];
         fill_rd_ff <= fills_ff[rd_row];
         vld_rd_ff  <= row_vld_ff[rd_row];
      end
   end

   always_comb begin
      row_vld_in = row_vld_ff;
      if (ctl.clr_all) begin
         row_vld_in = '0;
      end else begin
         if (ctl.row_inv) begin
            row_vld_in[wr_row] = 1'b0;
         end
         if (ctl.fill_we) begin
            row_vld_in[wr_row] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else begin
         row_vld_ff <= row_vld_in;
      end
   end

   assign rd_cell = cell_rd_ff;
   assign rd_fill = vld_rd_ff ? fill_rd_ff : '0;

endmodule

/* design/atcw_seq.sv */
// Item sequencer: escape parser, literal replay, cursor and scroll control, reads.
// Depends on atcw_pkg; drives atcw_store through a store_ctl_type bundle.
module atcw_seq #(
   parameter int COLUMNS = 120,
   parameter int ROWS = 35,
   localparam int RW = $clog2(ROWS),
   localparam int CW = $clog2(COLUMNS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_kind,
   input  logic [7:0]              req_byte,
   input  logic [5:0]              req_row,
   input  logic [6:0]              req_column,
   output logic                    res_valid,
   input  logic                    res_ready,
   output atcw_pkg::result_type    res,
   output atcw_pkg::store_ctl_type ctl,
   output logic [RW-1:0]           wr_row,
   output logic [CW-1:0]           wr_col,
   output logic [10:0]             wr_cell,
   output logic [CW-1:0]           fill_value,
   output logic [RW-1:0]           rd_row,
   output logic [CW-1:0]           rd_col,
   input  logic [10:0]             rd_cell,
   input  logic [CW-1:0]           rd_fill
);

   atcw_pkg::seq_state_type state_ff, state_in;
   logic [RW-1:0] top_ff, top_in;
   logic [RW-1:0] bot_ff, bot_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [3:0]    colour_ff, colour_in;
   logic [2:0]    esc_ff, esc_in;
   logic [7:0]    digit_ff, digit_in;
   logic [7:0]    q0_ff, q0_in;
   logic [7:0]    q1_ff, q1_in;
   logic          q2_ff, q2_in;
   logic [2:0]    lit_st_ff, lit_st_in;
   logic [1:0]    lit_idx_ff, lit_idx_in;
   logic [1:0]    kind_ff, kind_in;
   logic [5:0]    row_ff, row_in;
   logic [6:0]    col_ff, col_in;
   logic          rd_ok_ff, rd_ok_in;

   logic [RW:0]   row_sum;
   logic          rd_ok;
   logic          hit;

   assign row_sum = (RW+1)'(top_ff) + (RW+1)'(row_ff);
   assign rd_row  = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
   assign rd_col  = CW'(col_ff);
   assign rd_ok   = (row_ff < 6'(ROWS)) && (8'(col_ff) < 8'(COLUMNS));
   assign hit     = (kind_ff == atcw_pkg::KIND_READ) && rd_ok_ff
                    && ((CW+7)'(col_ff) < (CW+7)'(rd_fill));

   always_comb begin
      logic       accept;
      logic       ok;
      logic       pt_en;
      logic [7:0] pt_byte;
      logic [7:0] b;
      logic       scroll;
      logic       print;
      logic [CW-1:0] cur_a;

      state_in   = state_ff;
      top_in     = top_ff;
      bot_in     = bot_ff;
      cursor_in  = cursor_ff;
      colour_in  = colour_ff;
      esc_in     = esc_ff;
      digit_in   = digit_ff;
      q0_in      = q0_ff;
      q1_in      = q1_ff;
      q2_in      = q2_ff;
      lit_st_in  = lit_st_ff;
      lit_idx_in = lit_idx_ff;
      kind_in    = kind_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rd_ok_in   = rd_ok_ff;
      ctl        = '0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      accept     = 1'b0;
      ok         = 1'b0;
      pt_en      = 1'b0;
      b          = q0_ff;
      pt_byte    = q0_ff;

      case (state_ff)
         atcw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
         end
         atcw_pkg::ST_STEP: begin
            case (esc_ff)
               atcw_pkg::E_NONE: begin
                  ok = 1'b1;
                  if (b == atcw_pkg::CH_ESC) begin
                     esc_in = atcw_pkg::E_ESC;
                  end else begin
                     pt_en = 1'b1;
                  end
               end
               atcw_pkg::E_ESC: begin
                  if (b == atcw_pkg::CH_BRACKET) begin
                     ok = 1'b1;
                     esc_in = atcw_pkg::E_BRACKET;
                  end
               end
               atcw_pkg::E_BRACKET: begin
                  if (b == atcw_pkg::CH_ZERO) begin
                     ok = 1'b1;
                     esc_in = atcw_pkg::E_ZERO;
                  end else if (b == atcw_pkg::CH_ONE) begin
                     ok = 1'b1;
                     esc_in = atcw_pkg::E_ONE;
                  end
               end
               atcw_pkg::E_ZERO: begin
                  if (b == atcw_pkg::CH_M) begin
                     ok = 1'b1;
                     colour_in = atcw_pkg::COLOUR_DEFAULT;
                     esc_in = atcw_pkg::E_NONE;
                  end
               end
               atcw_pkg::E_ONE: begin
                  if (b == atcw_pkg::CH_SEMI) begin
                     ok = 1'b1;
                     esc_in = atcw_pkg::E_SEMI;
                  end
               end
               atcw_pkg::E_SEMI: begin
                  if (b == atcw_pkg::CH_THREE) begin
                     ok = 1'b1;
                     esc_in = atcw_pkg::E_THREE;
                  end
               end
               atcw_pkg::E_THREE: begin
                  if (b != atcw_pkg::CH_NUL) begin
                     ok = 1'b1;
                     digit_in = b;
                     esc_in = atcw_pkg::E_DIGIT;
                  end
               end
               default: begin
                  if (b == atcw_pkg::CH_M) begin
                     ok = 1'b1;
                     colour_in = 4'(digit_ff + atcw_pkg::COLOUR_BASE - atcw_pkg::CH_ZERO);
                     esc_in = atcw_pkg::E_NONE;
                  end
               end
            endcase
            if (ok) begin
               if (q2_ff) begin
                  q0_in = q1_ff;
                  q2_in = 1'b0;
               end else begin
                  state_in = atcw_pkg::ST_DONE;
               end
            end else begin
               // broken escape: held digit and breaking byte go back in front
               esc_in     = atcw_pkg::E_NONE;
               q0_in      = (esc_ff == atcw_pkg::E_DIGIT) ? digit_ff : b;
               q1_in      = b;
               q2_in      = (esc_ff == atcw_pkg::E_DIGIT);
               lit_st_in  = esc_ff;
               lit_idx_in = 2'd0;
               if (atcw_pkg::lit_len(esc_ff) != 3'd0) begin
                  state_in = atcw_pkg::ST_LIT;
               end
            end
         end
         atcw_pkg::ST_LIT: begin
            pt_en   = 1'b1;
            pt_byte = atcw_pkg::lit_byte(lit_st_ff, lit_idx_ff);
            if ((3'(lit_idx_ff) + 3'd1) == atcw_pkg::lit_len(lit_st_ff)) begin
               state_in = atcw_pkg::ST_STEP;
            end else begin
               lit_idx_in = lit_idx_ff + 2'd1;
            end
         end
         atcw_pkg::ST_RD: begin
            ctl.rd   = rd_ok;
            rd_ok_in = rd_ok;
            state_in = atcw_pkg::ST_DONE;
         end
         atcw_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               req_ready = 1'b1;
               accept    = req_valid;
               state_in  = atcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = atcw_pkg::ST_IDLE;
         end
      endcase

      // text put: scroll, then store a printable byte on the bottom row
      scroll = pt_en && ((pt_byte == atcw_pkg::CH_NL) || (cursor_ff >= CW'(COLUMNS)));
      print  = pt_en && (pt_byte != atcw_pkg::CH_NL)
               && (pt_byte >= atcw_pkg::CH_FIRST) && (pt_byte <= atcw_pkg::CH_LAST);
      cur_a  = cursor_ff;
      if (scroll) begin
         top_in    = (top_ff == RW'(ROWS - 1)) ? '0 : top_ff + 1'b1;
         bot_in    = (bot_ff == RW'(ROWS - 1)) ? '0 : bot_ff + 1'b1;
         cur_a     = '0;
         cursor_in = '0;
      end
      ctl.row_inv = scroll;
      ctl.cell_we = print;
      ctl.fill_we = print;
      wr_row      = bot_in;
      wr_col      = cur_a;
      wr_cell     = {pt_byte[6:0], colour_ff};
      fill_value  = CW'(cur_a + 1'b1);
      if (print) begin
         cursor_in = CW'(cur_a + 1'b1);
      end

      if (accept) begin
         kind_in = req_kind;
         row_in  = req_row;
         col_in  = req_column;
         case (req_kind)
            atcw_pkg::KIND_TEXT: begin
               q0_in    = req_byte;
               q2_in    = 1'b0;
               state_in = atcw_pkg::ST_STEP;
            end
            atcw_pkg::KIND_READ: begin
               state_in = atcw_pkg::ST_RD;
            end
            atcw_pkg::KIND_CLEAR: begin
               ctl.clr_all = 1'b1;
               cursor_in   = '0;
               esc_in      = atcw_pkg::E_NONE;
               state_in    = atcw_pkg::ST_DONE;
            end
            default: begin
               state_in = atcw_pkg::ST_DONE;
            end
         endcase
      end

      res.cell_char     = hit ? rd_cell[10:4] : 7'd0;
      res.cell_colour   = hit ? rd_cell[3:0] : 4'd0;
      res.cursor_column = 7'(cursor_ff);
      res.colour_now    = colour_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= atcw_pkg::ST_IDLE;
         top_ff    <= '0;
         bot_ff    <= RW'(ROWS - 1);
         cursor_ff <= '0;
         colour_ff <= atcw_pkg::COLOUR_DEFAULT;
         esc_ff    <= atcw_pkg::E_NONE;
         digit_ff  <= '0;
         q2_ff     <= 1'b0;
         rd_ok_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         cursor_ff <= cursor_in;
         colour_ff <= colour_in;
         esc_ff    <= esc_in;
         digit_ff  <= digit_in;
         q2_ff     <= q2_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
      lit_st_ff  <= lit_st_in;
      lit_idx_ff <= lit_idx_in;
      kind_ff    <= kind_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
   end

endmodule

/* design/ansi_text_console_writer.sv */
// ANSI text console writer top level: sequencer, grid store and response register.
// Depends on atcw_pkg, atcw_if, atcw_store and atcw_seq.
//
// Usage: one request transaction on req_chan gives exactly one response
// transaction on rsp_chan, in order. kind 0 feeds a text byte (ESC[0m and
// ESC[1;3<d>m set the colour, newline or a full bottom row scrolls), kind 1
// reads one visible cell, kind 2 empties the grid and homes the cursor.
// Every response carries the cursor column and current colour after the item.
// Timing: a text byte goes from acceptance through the step state to the done
// state; when an escape breaks, the literal state first replays up to 4 literal
// bytes, then the held digit and the breaking byte are stepped again and can
// break a fresh escape once more; the sequencer handles one byte per cycle. A
// read goes through the read state, where the grid memory read is registered, to
// the done state; clear and unused kinds go straight to done. The response is
// registered, so it appears in the cycle after the item finishes.
// Reset empties every row (row valid bits cleared at once), sets colour 7 and
// the cursor to 0; the grid memory itself keeps stale data that is never shown.
// A stalled rsp_chan holds its response; one more item can finish behind it,
// then req_chan.ready stays low until the response is taken.
module ansi_text_console_writer #(
   parameter int COLUMNS = 120,
   parameter int ROWS = 35
) (
   input logic        clock,
   input logic        reset,
   atcw_req_if.sink   req_chan,
   atcw_rsp_if.source rsp_chan
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS + 1);

   atcw_pkg::store_ctl_type ctl;
   atcw_pkg::result_type    res;
   atcw_pkg::result_type    out_data_ff;
   logic                    out_valid_ff;
   logic                    res_valid;
   logic                    res_ready;
   logic [RW-1:0]           wr_row;
   logic [CW-1:0]           wr_col;
   logic [10:0]             wr_cell;
   logic [CW-1:0]           fill_value;
   logic [RW-1:0]           rd_row;
   logic [CW-1:0]           rd_col;
   logic [10:0]             rd_cell;
   logic [CW-1:0]           rd_fill;

   atcw_seq #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_kind   (req_chan.kind),
      .req_byte   (req_chan.data_byte),
      .req_row    (req_chan.row),
      .req_column (req_chan.column),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .ctl        (ctl),
      .wr_row     (wr_row),
      .wr_col     (wr_col),
      .wr_cell    (wr_cell),
      .fill_value (fill_value),
      .rd_row     (rd_row),
      .rd_col     (rd_col),
      .rd_cell    (rd_cell),
      .rd_fill    (rd_fill)
   );

   atcw_store #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_row     (wr_row),
      .wr_col     (wr_col),
      .wr_cell    (wr_cell),
      .fill_value (fill_value),
      .rd_row     (rd_row),
      .rd_col     (rd_col),
      .rd_cell    (rd_cell),
      .rd_fill    (rd_fill)
   );

   assign res_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_data_ff <= res;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.cell_char     = out_data_ff.cell_char;
   assign rsp_chan.cell_colour   = out_data_ff.cell_colour;
   assign rsp_chan.cursor_column = out_data_ff.cursor_column;
   assign rsp_chan.colour_now    = out_data_ff.colour_now;

endmodule

/* tb/sv/ansi_text_console_writer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ansi_text_console_writer: a directed table, then random text,
// escape, read, clear and unused-kind traffic with bursty handshakes, checked against an in-bench model.
// Depends on atcw_pkg, the channel interfaces in atcw_if and the ansi_text_console_writer RTL.
module ansi_text_console_writer_tb;
   import atcw_pkg::*;

   localparam int COLS = 120;
   localparam int ROWS = 35;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT = 400000;
   localparam result_type NO_RESULT = '0;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [5:0] row;
      logic [6:0] column;
      logic       fixed;
      result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   atcw_req_if req_chan ();
   atcw_rsp_if rsp_chan ();

   ansi_text_console_writer #(
      .COLUMNS(COLS),
      .ROWS(ROWS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // console model state
   logic [6:0] scr_char [ROWS * COLS];
   logic [3:0] scr_colour [ROWS * COLS];
   int         line_len [ROWS];
   int         top_line;
   int         cur_col;
   logic [3:0] pen_colour;
   logic [2:0] esc_stage;
   logic [7:0] esc_digit;

   result_type pending_results[$];
   int         mismatch_count = 0;
   int         items_sent = 0;
   int         burst_left = 0;

   // rows with a typed-in result have fixed set
   stim_row_type directed [27] = '{
      '{KIND_READ,  8'h00,      6'd0,  7'd0,   1'b1, '{7'd0, 4'd0, 7'd0, 4'd7}},
      '{KIND_READ,  8'h00,      6'd63, 7'd127, 1'b1, '{7'd0, 4'd0, 7'd0, 4'd7}},
      '{KIND_TEXT,  8'h41,      6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  8'hFF,      6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_NL,      6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_UNUSED, 8'hFF,     6'd63, 7'd127, 1'b0, NO_RESULT},
      '{KIND_CLEAR, 8'h00,      6'd0,  7'd0,   1'b1, '{7'd0, 4'd0, 7'd0, 4'd7}},
      '{KIND_TEXT,  CH_ESC,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_BRACKET, 6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_ONE,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_SEMI,    6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_THREE,   6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  8'h37,      6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_M,       6'd0,  7'd0,   1'b1, '{7'd0, 4'd0, 7'd0, 4'd15}},
      '{KIND_TEXT,  CH_ESC,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_BRACKET, 6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_ONE,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_SEMI,    6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_THREE,   6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_NUL,     6'd0,  7'd0,   1'b1, '{7'd0, 4'd0, 7'd4, 4'd15}},
      '{KIND_TEXT,  CH_ESC,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_BRACKET, 6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_ESC,     6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_BRACKET, 6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_ZERO,    6'd0,  7'd0,   1'b0, NO_RESULT},
      '{KIND_TEXT,  CH_M,       6'd0,  7'd0,   1'b1, '{7'd0, 4'd0, 7'd5, 4'd7}},
      '{KIND_READ,  8'h00,      6'd34, 7'd0,   1'b0, NO_RESULT}
   };

   function automatic void emit_char(input logic [7:0] b);
      int r;
      if (b == CH_NL || cur_col >= COLS) begin
         top_line = (top_line + 1) % ROWS;
         line_len[(top_line + ROWS - 1) % ROWS] = 0;
         cur_col = 0;
         if (b == CH_NL) return;
      end
      if (b < CH_FIRST || b > CH_LAST) return;
      r = (top_line + ROWS - 1) % ROWS;
      scr_char[r * COLS + cur_col] = b[6:0];
      scr_colour[r * COLS + cur_col] = pen_colour;
      cur_col++;
      line_len[r] = cur_col;
   endfunction

   function automatic void feed_text_byte(input logic [7:0] first);
      logic [7:0] work[$];
      logic [7:0] b;
      logic [7:0] sum;
      logic [2:0] st;
      logic       ok;
      work.push_back(first);
      while (work.size() > 0) begin
         b = work.pop_front();
         ok = 1'b0;
         case (esc_stage)
            E_NONE: begin
               if (b == CH_ESC) esc_stage = E_ESC;
               else emit_char(b);
               ok = 1'b1;
            end
            E_ESC: if (b == CH_BRACKET) begin
               esc_stage = E_BRACKET;
               ok = 1'b1;
            end
            E_BRACKET: if (b == CH_ZERO) begin
               esc_stage = E_ZERO;
               ok = 1'b1;
            end else if (b == CH_ONE) begin
               esc_stage = E_ONE;
               ok = 1'b1;
            end
            E_ZERO: if (b == CH_M) begin
               pen_colour = COLOUR_DEFAULT;
               esc_stage = E_NONE;
               ok = 1'b1;
            end
            E_ONE: if (b == CH_SEMI) begin
               esc_stage = E_SEMI;
               ok = 1'b1;
            end
            E_SEMI: if (b == CH_THREE) begin
               esc_stage = E_THREE;
               ok = 1'b1;
            end
            E_THREE: if (b != CH_NUL) begin
               esc_digit = b;
               esc_stage = E_DIGIT;
               ok = 1'b1;
            end
            default: if (b == CH_M) begin
               sum = COLOUR_BASE + esc_digit - CH_ZERO;
               pen_colour = sum[3:0];
               esc_stage = E_NONE;
               ok = 1'b1;
            end
         endcase
         if (!ok) begin
            st = esc_stage;
            esc_stage = E_NONE;
            if (st >= E_BRACKET) emit_char(CH_BRACKET);
            if (st == E_ZERO) emit_char(CH_ZERO);
            if (st >= E_ONE) emit_char(CH_ONE);
            if (st >= E_SEMI) emit_char(CH_SEMI);
            if (st >= E_THREE) emit_char(CH_THREE);
            // held digit and breaking byte go back through the parser first
            work.push_front(b);
            if (st == E_DIGIT) work.push_front(esc_digit);
            while (work.size() > 4) void'(work.pop_back());
         end
      end
   endfunction

   function automatic result_type console_step(input logic [1:0] kind, input logic [7:0] data,
                                               input logic [5:0] row, input logic [6:0] column);
      result_type res;
      int         p;
      res = '0;
      case (kind)
         KIND_TEXT: feed_text_byte(data);
         KIND_READ: if (row < ROWS && column < COLS) begin
            p = (top_line + row) % ROWS;
            if (column < line_len[p]) begin
               res.cell_char = scr_char[p * COLS + column];
               res.cell_colour = scr_colour[p * COLS + column];
            end
         end
         KIND_CLEAR: begin
            foreach (line_len[i]) line_len[i] = 0;
            cur_col = 0;
            esc_stage = E_NONE;
         end
         default: ;
      endcase
      res.cursor_column = cur_col[6:0];
      res.colour_now = pen_colour;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                            input logic [5:0] row, input logic [6:0] column,
                            input logic fixed, input result_type want);
      int         gap;
      logic       taken;
      result_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.data_byte <= data;
      req_chan.row <= row;
      req_chan.column <= column;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
      predicted = console_step(kind, data, row, column);
      pending_results.push_back(fixed ? want : predicted);
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] b);
      send_item(KIND_TEXT, b, 6'($urandom_range(0, 63)), 7'($urandom_range(0, 127)),
                1'b0, NO_RESULT);
   endtask

   task automatic send_escape();
      logic [7:0] seq[$];
      logic [7:0] brk;
      int         cut;
      seq.push_back(CH_ESC);
      seq.push_back(CH_BRACKET);
      if ($urandom_range(0, 2) == 0) begin
         seq.push_back(CH_ZERO);
      end else begin
         seq.push_back(CH_ONE);
         seq.push_back(CH_SEMI);
         seq.push_back(CH_THREE);
         case ($urandom_range(0, 5))
            0: seq.push_back(CH_NUL);
            1: seq.push_back(CH_ESC);
            2: seq.push_back(8'($urandom_range(0, 255)));
            default: seq.push_back(8'($urandom_range(8'h30, 8'h3F)));
         endcase
      end
      seq.push_back(CH_M);
      if ($urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, seq.size() - 1);
         while (seq.size() > cut) void'(seq.pop_back());
         case ($urandom_range(0, 3))
            0: brk = CH_ESC;
            1: brk = CH_NL;
            2: brk = 8'($urandom_range(CH_FIRST, CH_LAST));
            default: brk = 8'($urandom_range(0, 255));
         endcase
         seq.push_back(brk);
      end
      foreach (seq[i]) send_text(seq[i]);
   endtask

   initial begin : stimulus
      int         pick;
      int         n;
      int         target;
      logic       drained;
      logic [5:0] rrow;
      logic [6:0] rcol;
      foreach (line_len[i]) line_len[i] = 0;
      top_line = 0;
      cur_col = 0;
      pen_colour = COLOUR_DEFAULT;
      esc_stage = E_NONE;
      esc_digit = 8'h00;
      drained = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.kind <= KIND_TEXT;
      req_chan.data_byte <= 8'h00;
      req_chan.row <= 6'd0;
      req_chan.column <= 7'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].kind, directed[i].data, directed[i].row, directed[i].column,
                   directed[i].fixed, directed[i].want);

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (!drained && items_sent >= target - RANDOM_ITEMS / 2) begin
            // let everything in flight come back before going on
            drained = 1'b1;
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
            burst_left = 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            send_escape();
         end else if (pick < 62) begin
            n = $urandom_range(1, 30);
            repeat (n) send_text(8'($urandom_range(CH_FIRST, CH_LAST)));
         end else if (pick < 66) begin
            send_text(CH_NL);
         end else if (pick < 69) begin
            send_text(8'($urandom_range(0, 255)));
         end else if (pick < 96) begin
            case ($urandom_range(0, 9))
               0, 1: rrow = 6'($urandom_range(0, ROWS - 1));
               2: rrow = 6'($urandom_range(0, 63));
               default: rrow = 6'($urandom_range(ROWS - 5, ROWS - 1));
            endcase
            case ($urandom_range(0, 9))
               0, 1, 2: rcol = 7'($urandom_range(0, COLS - 1));
               3: rcol = 7'($urandom_range(0, 127));
               default: rcol = 7'($urandom_range(0, cur_col + 1));
            endcase
            send_item(KIND_READ, 8'($urandom_range(0, 255)), rrow, rcol, 1'b0, NO_RESULT);
         end else if (pick < 97) begin
            send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      7'($urandom_range(0, 127)), 1'b0, NO_RESULT);
         end else begin
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                      7'($urandom_range(0, 127)), 1'b0, NO_RESULT);
         end
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : response_sink
      int cyc;
      int mode;
      int mode_left;
      int hold_left;
      cyc = 0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         // one long hold-off so the block backs up into req_chan
         if (cyc == 1200) hold_left = 300;
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 2) == 0);
               default: rsp_chan.ready <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin : response_check
      logic       taken;
      result_type got;
      result_type want;
      forever begin
         @(negedge clock);
         taken = !reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1;
         got.cell_char = rsp_chan.cell_char;
         got.cell_colour = rsp_chan.cell_colour;
         got.cursor_column = rsp_chan.cursor_column;
         got.colour_now = rsp_chan.colour_now;
         @(posedge clock);
         if (taken) begin
            if (pending_results.size() == 0) begin
               report_mismatch("transaction with nothing expected", 0, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.cell_char !== want.cell_char)
                  report_mismatch("cell_char", int'(got.cell_char), int'(want.cell_char));
               if (got.cell_colour !== want.cell_colour)
                  report_mismatch("cell_colour", int'(got.cell_colour),
                                  int'(want.cell_colour));
               if (got.cursor_column !== want.cursor_column)
                  report_mismatch("cursor_column", int'(got.cursor_column),
                                  int'(want.cursor_column));
               if (got.colour_now !== want.colour_now)
                  report_mismatch("colour_now", int'(got.colour_now), int'(want.colour_now));
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
